// ----- rtl/block_rate_one_pole_slew_macros.svh -----
// Assertion macros for the slew filter RTL.
`ifndef BLOCK_RATE_ONE_POLE_SLEW_MACROS_SVH
`define BLOCK_RATE_ONE_POLE_SLEW_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BSL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BSL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bsl_pkg.sv -----
// Types, constants and Q1.31 arithmetic helpers for the block-rate slew filter.
package bsl_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic signed [DATA_W-1:0] Q31_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q31_MIN   = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] SNAP_POS  = 32'sh0000_4000;
  localparam logic signed [DATA_W-1:0] SNAP_NEG  = -32'sh0000_4000;

  localparam logic [CFG_IDX_W-1:0] REG_SLEW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE = 1'b1;

  typedef enum logic [1:0] {
    KIND_ADVANCE = 2'd0,
    KIND_SYNC    = 2'd1,
    KIND_LOAD    = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ACC  = 3'b010,
    ST_SQR  = 3'b100
  } cstate_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] level;
    logic                     settled;
  } res_t;

  // Clamp a 33-bit signed value into Q1.31.
  function automatic logic signed [DATA_W-1:0] sat33(input logic [DATA_W:0] v);
    if (v[DATA_W] != v[DATA_W-1]) begin
      return v[DATA_W] ? Q31_MIN : Q31_MAX;
    end
    return v[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
    return sat33({a[DATA_W-1], a} + {b[DATA_W-1], b});
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_sub(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
    return sat33({a[DATA_W-1], a} - {b[DATA_W-1], b});
  endfunction

  // Q1.31 multiply, floor rounding; only -1 * -1 overflows.
  function automatic logic signed [DATA_W-1:0] qmul(input logic signed [DATA_W-1:0] a,
                                                    input logic signed [DATA_W-1:0] b);
    logic signed [2*DATA_W-1:0] p;
    p = a * b;
    return sat33(p[2*DATA_W-1:DATA_W-1]);
  endfunction

endpackage

// ----- rtl/block_rate_one_pole_slew.sv -----
// Top level of the block-rate one-pole slew filter.
// One item per clock while in_ready is high: each accepted item updates the
// filter state in the same cycle it transfers (one 32x32 multiply-add path)
// and its result is pushed into a two-entry output queue, so input keeps
// flowing while one result waits; a full queue holds in_ready low. After any
// configuration write the block coefficient is re-derived by a shared
// multiplier, one accumulate or squaring step per cycle; trivial cases are
// set directly, else square-and-multiply runs; in_ready stays low meanwhile.
`include "block_rate_one_pole_slew_macros.svh"

module block_rate_one_pole_slew import bsl_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               kind,
  input  logic signed [DATA_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] level,
  output logic                     settled
);

  logic signed [DATA_W-1:0] coeff;
  logic                     busy;
  logic                     space;
  logic                     accept;
  res_t                     res;
  res_t                     out_data;

  assign in_ready = space && !busy;
  assign accept   = in_valid && in_ready;
  assign level    = out_data.level;
  assign settled  = out_data.settled;

  bsl_coeff u_coeff (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coeff     (coeff),
    .busy      (busy)
  );

  bsl_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .kind   (kind),
    .value  (value),
    .coeff  (coeff),
    .res    (res)
  );

  bsl_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `BSL_ASSERT_NEXT(a_cfg_blocks, cfg_we, busy && !in_ready, "config write did not stall input")
  `BSL_ASSERT_NEXT(a_result_queued, accept, out_valid, "accepted item produced no result")
  `BSL_ASSERT_NOW(a_load_level, accept && (kind == KIND_LOAD), res.level == value, "load level mismatch")
  `BSL_ASSERT_NOW(a_settled_sync, accept && (kind != KIND_SYNC), !res.settled, "settled set on non-sync item")

endmodule

// ----- rtl/bsl_coeff.sv -----
// Configuration registers and iterative square-and-multiply for the block coefficient.
module bsl_coeff import bsl_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  output logic signed [DATA_W-1:0] coeff,
  output logic                     busy
);

  logic signed [DATA_W-1:0] slew;
  logic [SIZE_W-1:0]        size;
  logic signed [DATA_W-1:0] acc;
  logic signed [DATA_W-1:0] base;
  logic [SIZE_W-1:0]        n;
  logic                     start;
  cstate_t                  state;

  logic signed [DATA_W-1:0] mul_a;
  logic signed [DATA_W-1:0] prod;

  // One shared multiplier: accumulate step or squaring step.
  assign mul_a = (state == ST_SQR) ? base : acc;
  assign prod  = qmul(mul_a, base);
  assign busy  = start || (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      slew  <= '0;
      size  <= SIZE_W'(1);
      coeff <= '0;
      start <= 1'b0;
      state <= ST_IDLE;
    end else if (cfg_we) begin
      // a write restarts the derivation
      if (cfg_index == REG_SLEW) begin
        slew <= cfg_data;
      end else begin
        size <= (cfg_data[SIZE_W-1:0] == '0) ? SIZE_W'(1) : cfg_data[SIZE_W-1:0];
      end
      start <= 1'b1;
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            start <= 1'b0;
            if (size <= SIZE_W'(1)) begin
              coeff <= slew;
            end else if (slew[DATA_W-1] || (slew == '0)) begin
              coeff <= '0;
            end else if (slew == Q31_MAX) begin
              coeff <= Q31_MAX;
            end else begin
              acc   <= Q31_MAX;
              base  <= slew;
              n     <= size;
              state <= ST_ACC;
            end
          end
        end
        ST_ACC: begin
          if (n[0]) begin
            acc <= prod;
          end
          if (n[SIZE_W-1:1] == '0) begin
            coeff <= n[0] ? prod : acc;
            state <= ST_IDLE;
          end else begin
            n     <= n >> 1;
            state <= ST_SQR;
          end
        end
        ST_SQR: begin
          base  <= prod;
          state <= ST_ACC;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/bsl_core.sv -----
// Filter state and the per-item update: advance, sync check, load.
module bsl_core import bsl_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic [1:0]               kind,
  input  logic signed [DATA_W-1:0] value,
  input  logic signed [DATA_W-1:0] coeff,
  output res_t                     res
);

  logic signed [DATA_W-1:0] level_q;
  logic signed [DATA_W-1:0] target_q;
  logic signed [DATA_W-1:0] level_next;
  logic signed [DATA_W-1:0] target_next;
  logic                     settled_next;
  logic signed [DATA_W-1:0] gap;
  logic signed [DATA_W-1:0] sync_gap;

  assign gap      = sat_sub(level_q, value);
  assign sync_gap = sat_sub(target_q, level_q);

  always_comb begin
    level_next   = level_q;
    target_next  = target_q;
    settled_next = 1'b0;
    case (kind_t'(kind))
      KIND_ADVANCE: begin
        target_next = value;
        level_next  = sat_add(value, qmul(coeff, gap));
      end
      KIND_SYNC: begin
        if (target_q == level_q) begin
          settled_next = 1'b1;
        end else if ((sync_gap < SNAP_POS) && (sync_gap > SNAP_NEG)) begin
          // close enough: snap, still reported unsettled
          level_next = target_q;
        end
      end
      KIND_LOAD: begin
        level_next  = value;
        target_next = value;
      end
      default: begin
      end
    endcase
  end

  assign res.level   = level_next;
  assign res.settled = settled_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_q  <= '0;
      target_q <= '0;
    end else if (accept) begin
      level_q  <= level_next;
      target_q <= target_next;
    end
  end

endmodule

// ----- rtl/bsl_outq.sv -----
// Two-entry result queue between the filter update and the output channel.
module bsl_outq import bsl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_data,
  output logic space,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  res_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign space     = (count != 2'd2);
  assign pop       = out_valid && out_ready;
  assign out_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
